// ===== sv/sql_lexer_unit_assert.svh =====
// ---------------------------------------------------------------------------
// SQL lexer assertion macros
// Shorthands for the concurrent checks used by the lexer checker.
// ---------------------------------------------------------------------------
`ifndef SQL_LEXER_UNIT_ASSERT_SVH
`define SQL_LEXER_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define SQLL_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SQLL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define SQLL_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/sqll_pkg.sv =====
// ---------------------------------------------------------------------------
// SQL lexer package
// Types, token kinds, keyword table and character helpers.
// ---------------------------------------------------------------------------
package sqll_pkg;

  localparam int SQLL_OFFSET_BITS   = 16;
  localparam int SQLL_KEYWORD_CHARS = 6;
  localparam int SQLL_RES_DEPTH     = 4;
  localparam logic [15:0] SQLL_LIMIT_RESET = 16'd4096;
  localparam int SQLL_NUM_WORDS     = 6;

  typedef enum logic [3:0] {
    K_STAR    = 4'd0,
    K_COMMA   = 4'd1,
    K_LPAREN  = 4'd2,
    K_RPAREN  = 4'd3,
    K_EQ      = 4'd4,
    K_LT      = 4'd5,
    K_GT      = 4'd6,
    K_SEMI    = 4'd7,
    K_STRING  = 4'd8,
    K_NUMBER  = 4'd9,
    K_KEYWORD = 4'd10,
    K_IDENT   = 4'd11,
    K_UNKNOWN = 4'd12,
    K_EOF     = 4'd13,
    K_ERROR   = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_NUMBER  = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_STOPPED = 3'd4
  } mode_t;

  typedef struct packed {
    logic        last;
    logic [15:0] total;
    logic [15:0] span;
    logic [15:0] start_res;
    kind_t       kind;
  } sqll_res_t;

  // which of the two result slots are pushed this cycle
  typedef struct packed {
    logic a;
    logic b;
  } sqll_push_t;

  // keywords, first letter in the high byte, lower case
  localparam logic [63:0] KW_WORD [SQLL_NUM_WORDS] = '{
    64'h0000_696e_7365_7274, // insert
    64'h0000_0000_696e_746f, // into
    64'h0000_7661_6c75_6573, // values
    64'h0000_7365_6c65_6374, // select
    64'h0000_0000_6672_6f6d, // from
    64'h0000_0077_6865_7265  // where
  };
  localparam logic [3:0] KW_LEN [SQLL_NUM_WORDS] = '{
    4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5
  };

  function automatic logic sqll_kw_match(input logic [63:0] word, input logic [3:0] len);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SQLL_NUM_WORDS; i++) begin
      hit = hit | ((len == KW_LEN[i]) && (word == KW_WORD[i]));
    end
    return hit;
  endfunction

  // one-byte symbol tokens; anything else reads as unknown
  function automatic kind_t sqll_sym_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      8'h2a:   k = K_STAR;
      8'h2c:   k = K_COMMA;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3d:   k = K_EQ;
      8'h3c:   k = K_LT;
      8'h3e:   k = K_GT;
      8'h3b:   k = K_SEMI;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/sqll_res_fifo.sv =====
// ---------------------------------------------------------------------------
// SQL lexer result queue
// Small queue that takes up to two result words a cycle and hands out one while out_ready is high.
// ---------------------------------------------------------------------------
module sqll_res_fifo import sqll_pkg::*; #(
  parameter int DEPTH = SQLL_RES_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  sqll_push_t push,
  input  sqll_res_t  res_a,
  input  sqll_res_t  res_b,
  output logic       room_two,
  output logic       out_valid,
  input  logic       out_ready,
  output sqll_res_t  out_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sqll_res_t      mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic [AW-1:0]  wr_ptr_b;
  logic [AW-1:0]  wr_ptr_next;
  logic [CW-1:0]  count_next;
  logic           pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign room_two  = (count <= CW'(DEPTH - 2));
  assign wr_ptr_b  = push.a ? wrap_inc(wr_ptr) : wr_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr;
    if (push.a) wr_ptr_next = wrap_inc(wr_ptr_next);
    if (push.b) wr_ptr_next = wrap_inc(wr_ptr_next);
    count_next = count + CW'(push.a) + CW'(push.b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.a) mem[wr_ptr] <= res_a;
    if (push.b) mem[wr_ptr_b] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) rd_ptr <= wrap_inc(rd_ptr);
    end
  end

endmodule

// ===== sv/sql_lexer_unit.sv =====
// ---------------------------------------------------------------------------
// SQL lexer
// Streams text bytes in and SQL tokens out: symbols, strings, numbers,
// identifiers and keywords, closed by an end-of-text or error word.
// ---------------------------------------------------------------------------
//  channel | signals                           | word
//  --------+-----------------------------------+------------------------------
//  s_      | s_tvalid s_tready s_tdata s_tlast | text byte, tlast = end of text
//  m_      | m_tvalid m_tready m_tdata m_tuser | token, tuser = kind,
//          | m_tlast                           | tlast = eof/error token
//  cfg_    | cfg_valid cfg_ready cfg_data      | token limit
//
//  One byte per cycle: the lexer state updates in the cycle a byte is taken.
//  A byte yields zero to two tokens into a four-entry result queue;
//  s_tready drops while that queue has fewer than two free entries.
//  Reset needs no clearing pass; token limit returns to 4096. Back
//  pressure on m_ only stalls through the queue.
// ---------------------------------------------------------------------------
module sql_lexer_unit import sqll_pkg::*; #(
  parameter int OFFSET_BITS   = SQLL_OFFSET_BITS,
  parameter int KEYWORD_CHARS = SQLL_KEYWORD_CHARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // at_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] start_res, [31:16] span, [47:32] total
  output logic [3:0]  m_tuser,   // [3:0] kind
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // token_limit
);

  localparam int PW = KEYWORD_CHARS * 8;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  logic [15:0]            token_limit;
  mode_t                  mode, mode_next;
  logic                   quote_char, quote_char_next;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] token_start, token_start_next;
  logic [15:0]            token_count, token_count_next;
  logic [OFFSET_BITS-1:0] stop_position, stop_position_next;
  logic [PW-1:0]          word_prefix, word_prefix_next;

  logic                   in_fire;
  logic [7:0]             c, lc;
  logic                   is_blank, is_num, is_letter, is_quote;
  logic [OFFSET_BITS-1:0] pos_inc, run_len;
  logic                   cont, run_emit, kw_hit;
  logic [15:0]            cnt_run, lim;
  logic                   limit_full, scan_tok, stop_now, start_ok, single;
  logic                   str_close, open_err;
  sqll_res_t              res_a, res_b;
  sqll_push_t             push;
  sqll_res_t              head;
  logic                   room_two;

  assign c         = s_tdata;
  assign lc        = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign is_blank  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) || (c == 8'h0d);
  assign is_num    = (c >= "0") && (c <= "9");
  assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  assign is_quote  = (c == 8'h27) || (c == 8'h22);

  assign in_fire   = s_tvalid && s_tready;
  assign s_tready  = room_two;
  assign cfg_ready = 1'b1;

  assign pos_inc = (position == POS_MAX) ? POS_MAX : position + 1'b1;
  assign run_len = position - token_start;

  assign cont = ((mode == MODE_NUMBER) && is_num) ||
                ((mode == MODE_IDENT) && (is_letter || is_num));
  assign run_emit = ((mode == MODE_NUMBER) || (mode == MODE_IDENT)) &&
                    (s_tlast || !cont);
  assign kw_hit = (run_len <= OFFSET_BITS'(KEYWORD_CHARS)) &&
                  sqll_kw_match(64'(word_prefix), 4'(run_len));

  assign cnt_run    = token_count + 16'(run_emit);
  assign lim        = (token_limit == '0) ? 16'd1 : token_limit;
  assign limit_full = ({1'b0, cnt_run} + 17'd1) >= {1'b0, lim};
  assign scan_tok   = !s_tlast && ((mode == MODE_IDLE) || run_emit) && !is_blank;
  assign stop_now   = scan_tok && limit_full;
  assign start_ok   = scan_tok && !limit_full;
  assign single     = start_ok && !is_quote && !is_num && !is_letter;
  assign str_close  = !s_tlast && (mode == MODE_STRING) &&
                      (c == (quote_char ? 8'h22 : 8'h27));
  assign open_err   = s_tlast && (mode == MODE_STRING);

  // next state
  always_comb begin
    mode_next          = mode;
    quote_char_next    = quote_char;
    position_next      = position;
    token_start_next   = token_start;
    token_count_next   = token_count;
    stop_position_next = stop_position;
    word_prefix_next   = word_prefix;
    if (s_tlast) begin
      mode_next          = MODE_IDLE;
      quote_char_next    = 1'b0;
      position_next      = '0;
      token_start_next   = '0;
      token_count_next   = '0;
      stop_position_next = '0;
      word_prefix_next   = '0;
    end else begin
      position_next    = pos_inc;
      token_count_next = cnt_run + 16'(str_close || single);
      unique case (mode)
        MODE_STOPPED: mode_next = MODE_STOPPED;
        MODE_STRING: begin
          if (str_close) mode_next = MODE_IDLE;
        end
        MODE_NUMBER, MODE_IDENT: begin
          if (run_emit) mode_next = MODE_IDLE;
          if (mode == MODE_IDENT && cont && run_len < OFFSET_BITS'(KEYWORD_CHARS)) begin
            word_prefix_next = {word_prefix[PW-9:0], lc};
          end
        end
        MODE_IDLE: mode_next = MODE_IDLE;
        default: mode_next = MODE_IDLE;
      endcase
      if (stop_now) begin
        mode_next          = MODE_STOPPED;
        stop_position_next = position;
      end
      if (start_ok) begin
        if (is_quote) begin
          mode_next        = MODE_STRING;
          quote_char_next  = (c == 8'h22);
          token_start_next = pos_inc;
        end else if (is_num) begin
          mode_next        = MODE_NUMBER;
          token_start_next = position;
        end else if (is_letter) begin
          mode_next        = MODE_IDENT;
          token_start_next = position;
          word_prefix_next = PW'(lc);
        end
      end
    end
  end

  // result words: slot a is a finished number/identifier, slot b the rest
  always_comb begin
    res_a.kind      = (mode == MODE_IDENT) ? (kw_hit ? K_KEYWORD : K_IDENT) : K_NUMBER;
    res_a.start_res = 16'(token_start);
    res_a.span      = 16'(run_len);
    res_a.total     = '0;
    res_a.last      = 1'b0;

    res_b.kind      = sqll_sym_kind(c);
    res_b.start_res = 16'(position);
    res_b.span      = 16'd1;
    res_b.total     = '0;
    res_b.last      = 1'b0;
    if (open_err) begin
      res_b.kind      = K_ERROR;
      res_b.start_res = '0;
      res_b.span      = '0;
      res_b.last      = 1'b1;
    end else if (s_tlast) begin
      res_b.kind      = K_EOF;
      res_b.start_res = 16'((mode == MODE_STOPPED) ? stop_position : position);
      res_b.span      = '0;
      res_b.total     = cnt_run;
      res_b.last      = 1'b1;
    end else if (str_close) begin
      res_b.kind      = K_STRING;
      res_b.start_res = 16'(token_start);
      res_b.span      = 16'(run_len);
    end

    push.a = in_fire && run_emit;
    push.b = in_fire && (s_tlast || str_close || single);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_limit   <= SQLL_LIMIT_RESET;
      mode          <= MODE_IDLE;
      quote_char    <= 1'b0;
      position      <= '0;
      token_start   <= '0;
      token_count   <= '0;
      stop_position <= '0;
      word_prefix   <= '0;
    end else begin
      if (cfg_valid) token_limit <= cfg_data;
      if (in_fire) begin
        mode          <= mode_next;
        quote_char    <= quote_char_next;
        position      <= position_next;
        token_start   <= token_start_next;
        token_count   <= token_count_next;
        stop_position <= stop_position_next;
        word_prefix   <= word_prefix_next;
      end
    end
  end

  sqll_res_fifo #(
    .DEPTH (SQLL_RES_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .room_two  (room_two),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = {head.total, head.span, head.start_res};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

// ===== sv/sqll_checker.sv =====
// ---------------------------------------------------------------------------
// SQL lexer checker
// Port-level checks on the token stream, bound to the lexer top level.
// ---------------------------------------------------------------------------
`include "sql_lexer_unit_assert.svh"

module sqll_checker import sqll_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  logic        stall;
  logic        tail;
  logic        mid;
  logic        fin_kind;
  logic        total_zero;
  logic [52:0] word;

  assign stall      = m_tvalid && !m_tready;
  assign tail       = m_tvalid && m_tlast;
  assign mid        = m_tvalid && !m_tlast;
  assign fin_kind   = (m_tuser == K_EOF) || (m_tuser == K_ERROR);
  assign total_zero = (m_tdata[47:32] == 16'd0);
  assign word       = {m_tlast, m_tuser, m_tdata};

  `SQLL_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid, "token out right after reset")
  `SQLL_ASSERT_NEXT(a_stall_hold, clk, rst, stall, m_tvalid && $stable(word), "word moved")
  `SQLL_ASSERT_IMPLY(a_last_kind, clk, rst, tail, fin_kind, "bad final kind")
  `SQLL_ASSERT_IMPLY(a_total_zero, clk, rst, mid, !fin_kind && total_zero, "stray count")

endmodule

bind sql_lexer_unit sqll_checker u_sqll_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// SQL lexer testbench
// Streams texts into the lexer and checks every token word against a
// cycle-free token predictor. Directed texts cover symbols, strings,
// numbers, end-of-text, open strings and the token limit. Random
// texts are built from SQL-like pieces plus noise. Both sides stall at
// random.
// ---------------------------------------------------------------------------
module tb_top;
  import sqll_pkg::*;

  localparam int unsigned POS_MAX = (1 << SQLL_OFFSET_BITS) - 1;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  sql_lexer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stimulus and expected tokens
  text_word_t  text_q [$];
  sqll_res_t   token_q [$];
  string       kw_list [6] = '{"insert", "into", "values", "select", "from", "where"};

  int unsigned tx_idle = 0;
  int unsigned rx_idle = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  int unsigned sent_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt = 0;
  text_word_t  nxt_word;
  sqll_res_t   want;

  // lexer state as the predictor sees it
  logic [15:0] lim_reg = SQLL_LIMIT_RESET;
  mode_t       lx_mode = MODE_IDLE;
  logic        lx_quote = 1'b0;
  int unsigned lx_pos = 0;
  int unsigned lx_tok_start = 0;
  int unsigned lx_count = 0;
  int unsigned lx_stop = 0;
  logic [47:0] lx_word = '0;

  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned sat_next(input int unsigned v);
    return (v >= POS_MAX) ? POS_MAX : v + 1;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit num_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit reserved_word(input logic [47:0] w, input int unsigned n);
    case (n)
      4: return (w == "into") || (w == "from");
      5: return w == "where";
      6: return (w == "insert") || (w == "values") || (w == "select");
      default: return 1'b0;
    endcase
  endfunction

  task automatic push_token(input kind_t k, input int unsigned st, input int unsigned len,
                            input int unsigned tot, input logic lst);
    sqll_res_t t;
    t.kind      = k;
    t.start_res = st[15:0];
    t.span      = len[15:0];
    t.total     = tot[15:0];
    t.last      = lst;
    token_q.push_back(t);
  endtask

  task automatic close_run(input int unsigned stop_at);
    int unsigned len;
    kind_t       k;
    len = stop_at - lx_tok_start;
    k = K_NUMBER;
    if (lx_mode == MODE_IDENT) k = reserved_word(lx_word, len) ? K_KEYWORD : K_IDENT;
    push_token(k, lx_tok_start, len, 0, 1'b0);
    lx_count++;
    lx_mode = MODE_IDLE;
  endtask

  task automatic clear_text();
    lx_mode = MODE_IDLE;
    lx_quote = 1'b0;
    lx_pos = 0;
    lx_tok_start = 0;
    lx_count = 0;
    lx_stop = 0;
    lx_word = '0;
  endtask

  // byte seen between tokens
  task automatic open_token(input logic [7:0] c, input int unsigned here);
    int unsigned lim;
    lim = (lim_reg == 16'd0) ? 1 : lim_reg;
    if (c == " " || c == "\t" || c == "\n" || c == "\r") begin
    end else if (lx_count + 1 >= lim) begin
      lx_mode = MODE_STOPPED;
      lx_stop = here;
    end else begin
      case (c)
        "*": push_token(K_STAR, here, 1, 0, 1'b0);
        ",": push_token(K_COMMA, here, 1, 0, 1'b0);
        "(": push_token(K_LPAREN, here, 1, 0, 1'b0);
        ")": push_token(K_RPAREN, here, 1, 0, 1'b0);
        "=": push_token(K_EQ, here, 1, 0, 1'b0);
        "<": push_token(K_LT, here, 1, 0, 1'b0);
        ">": push_token(K_GT, here, 1, 0, 1'b0);
        ";": push_token(K_SEMI, here, 1, 0, 1'b0);
        "'", "\"": begin
          lx_mode = MODE_STRING;
          lx_quote = (c == "\"");
          lx_tok_start = sat_next(here);
        end
        default: begin
          if (num_byte(c)) begin
            lx_mode = MODE_NUMBER;
            lx_tok_start = here;
          end else if (letter_byte(c)) begin
            lx_mode = MODE_IDENT;
            lx_tok_start = here;
            lx_word = {40'h0, to_lower(c)};
          end else begin
            push_token(K_UNKNOWN, here, 1, 0, 1'b0);
          end
        end
      endcase
      // symbols and unknown bytes are complete tokens already
      if (lx_mode == MODE_IDLE) lx_count++;
    end
  endtask

  task automatic lex_predict(input logic [7:0] c, input logic fin);
    int unsigned here;
    here = lx_pos;
    if (fin) begin
      if (lx_mode == MODE_STRING) begin
        push_token(K_ERROR, 0, 0, 0, 1'b1);
      end else begin
        if (lx_mode == MODE_NUMBER || lx_mode == MODE_IDENT) close_run(here);
        push_token(K_EOF, (lx_mode == MODE_STOPPED) ? lx_stop : here, 0, lx_count, 1'b1);
      end
      clear_text();
    end else begin
      lx_pos = sat_next(lx_pos);
      case (lx_mode)
        MODE_STOPPED: ;
        MODE_STRING: begin
          if (c == (lx_quote ? "\"" : "'")) begin
            push_token(K_STRING, lx_tok_start, here - lx_tok_start, 0, 1'b0);
            lx_count++;
            lx_mode = MODE_IDLE;
          end
        end
        MODE_NUMBER: begin
          if (!num_byte(c)) begin
            close_run(here);
            open_token(c, here);
          end
        end
        MODE_IDENT: begin
          if (letter_byte(c) || num_byte(c)) begin
            if (here - lx_tok_start < SQLL_KEYWORD_CHARS) lx_word = {lx_word[39:0], to_lower(c)};
          end else begin
            close_run(here);
            open_token(c, here);
          end
        end
        default: open_token(c, here);
      endcase
    end
  endtask

  // sender: one word at a time from text_q, random gaps between words
  always @(negedge clk) begin
    if (rst) begin
    end else if (s_tvalid && taken_cnt != sent_cnt) begin
      // word still waiting for s_tready
    end else if (tx_gap != 0) begin
      s_tvalid <= 1'b0;
      tx_gap--;
    end else if (text_q.size() != 0) begin
      nxt_word = text_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata  <= nxt_word.ch;
      s_tlast  <= nxt_word.fin;
      sent_cnt++;
      tx_gap = pick_gap(tx_idle);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // receiver back pressure
  always @(negedge clk) begin
    if (rx_gap != 0) begin
      m_tready <= 1'b0;
      rx_gap--;
    end else begin
      m_tready <= 1'b1;
      rx_gap = pick_gap(rx_idle);
    end
  end

  task automatic field_err(input string name, input int unsigned exp_v, input int unsigned got_v);
    $display("%0t: token %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        lex_predict(s_tdata, s_tlast);
        taken_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, expected none, got kind %0d start %0d span %0d",
                   $time, m_tuser, m_tdata[15:0], m_tdata[31:16]);
          err_cnt++;
        end else begin
          want = token_q.pop_front();
          if (m_tuser !== want.kind) field_err("kind", want.kind, m_tuser);
          if (m_tdata[15:0] !== want.start_res) field_err("start", want.start_res, m_tdata[15:0]);
          if (m_tdata[31:16] !== want.span) field_err("span", want.span, m_tdata[31:16]);
          if (m_tdata[47:32] !== want.total) field_err("total", want.total, m_tdata[47:32]);
          if (m_tlast !== want.last) field_err("last", want.last, m_tlast);
        end
      end
    end
  end

  task automatic put_byte(input logic [7:0] c);
    text_q.push_back('{ch: c, fin: 1'b0});
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_end();
    text_q.push_back('{ch: 8'($urandom_range(0, 255)), fin: 1'b1});
  endtask

  function automatic logic [7:0] rand_alpha();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  task automatic put_string_lit(input bit closed);
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(0, 1) ? "\"" : "'";
    put_byte(q);
    repeat ($urandom_range(0, 8)) begin
      c = 8'($urandom_range(0, 255));
      if (c == q) c = c ^ 8'h80;
      put_byte(c);
    end
    if (closed) put_byte(q);
  endtask

  // one random text: mostly SQL-like pieces, some noise
  task automatic gen_text();
    int unsigned sel;
    string       s;
    string       sym;
    string       blanks;
    logic [7:0]  c;
    sym = "*,()=<>;";
    blanks = " \t\n\r";
    repeat ($urandom_range(0, 12)) begin
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        s = kw_list[$urandom_range(0, 5)];
        for (int i = 0; i < s.len(); i++) begin
          c = s[i];
          if ($urandom_range(0, 1)) c = c - 8'd32;
          put_byte(c);
        end
        if ($urandom_range(0, 4) == 0) put_byte(rand_alpha());
      end else if (sel < 36) begin
        put_byte(rand_alpha());
        repeat ($urandom_range(0, 9)) begin
          if ($urandom_range(0, 3) == 0) put_byte(8'("0" + $urandom_range(0, 9)));
          else put_byte(rand_alpha());
        end
      end else if (sel < 48) begin
        repeat ($urandom_range(1, 6)) put_byte(8'("0" + $urandom_range(0, 9)));
      end else if (sel < 70) begin
        put_byte(sym[$urandom_range(0, 7)]);
      end else if (sel < 80) begin
        put_string_lit(1'b1);
      end else if (sel < 88) begin
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(blanks[$urandom_range(0, 3)]);
      end
      if ($urandom_range(0, 1)) put_byte(blanks[$urandom_range(0, 3)]);
    end
    if ($urandom_range(0, 19) == 0) put_string_lit(1'b0);
    put_end();
  endtask

  task automatic drain();
    do @(posedge clk);
    while (text_q.size() != 0 || s_tvalid || token_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lim_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_idling();
    int unsigned lvl [4] = '{0, 15, 40, 70};
    tx_idle = lvl[$urandom_range(0, 3)];
    rx_idle = lvl[$urandom_range(0, 3)];
  endtask

  initial begin
    int unsigned r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed texts at the reset limit
    tx_idle = 20;
    rx_idle = 20;
    put_str("*,()=<>;");
    put_end();
    put_str("'a\"'\t\"\"\n");
    put_byte(8'h00);
    put_byte(8'hff);
    put_str("\rSel_9 42");
    put_end();
    put_str("'x");
    put_end();
    put_end();
    drain();

    // limit reached at once, limit zero, limit after one token
    write_limit(16'd1);
    put_str(" ab");
    put_end();
    drain();
    write_limit(16'd0);
    put_str("x;");
    put_end();
    drain();
    write_limit(16'd2);
    put_str("a b");
    put_end();
    drain();

    while (sent_cnt < 1700) begin
      r = $urandom_range(0, 9);
      if (r < 5) write_limit(16'($urandom_range(1, 12)));
      else if (r < 7) write_limit(SQLL_LIMIT_RESET);
      else if (r == 7) write_limit(16'hffff);
      else write_limit(16'($urandom_range(1, 65535)));
      pick_idling();
      repeat ($urandom_range(4, 12)) gen_text();
      drain();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #(20 * 1500000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sqll_pkg.sv
sv/sqll_res_fifo.sv
sv/sql_lexer_unit.sv
sv/sqll_checker.sv
tb/tb_top.sv
